// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that vanish when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hdl/mikd_pkg.sv
// ----------------------------------------------------------------------------
// mikd_pkg
// shared widths, codes and controller/datapath handshake types
// ----------------------------------------------------------------------------
`default_nettype none

package mikd_pkg;

    // field widths
    localparam int ENV_W   = 16;
    localparam int SYM_W   = 3;
    localparam int CNT_W   = 16;
    localparam int RUN_W   = 24;
    localparam int THR_W   = 8;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // default number of half-dot bins
    localparam int NUM_BINS_DEF = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR  = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] FAST_RST = 16'd6000;
    localparam logic [CFG_W-1:0] SLOW_RST = 16'd8571;
    localparam logic [THR_W-1:0] THR_RST  = 8'd32;
    localparam logic [ENV_W-1:0] FLOOR_RST = 16'd7;

    // symbol codes
    localparam logic [SYM_W-1:0] SYM_NONE = 3'd0;
    localparam logic [SYM_W-1:0] SYM_DOT  = 3'd1;
    localparam logic [SYM_W-1:0] SYM_DASH = 3'd2;
    localparam logic [SYM_W-1:0] SYM_GAP  = 3'd3;
    localparam logic [SYM_W-1:0] SYM_END  = 3'd4;

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // commands from controller to datapath
    typedef struct packed {
        logic load;    // latch sample, update bin maximum and count
        logic scan;    // one step of the minimum scan
        logic roll;    // last scan step, close the bin
        logic mul;     // threshold product and timing limits
        logic commit;  // key decision, timer update, result out
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic roll_needed;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// File: hdl/mikd_env_if.sv
// ----------------------------------------------------------------------------
// mikd_env_if
// envelope sample channel
// ----------------------------------------------------------------------------
`default_nettype none

interface mikd_env_if;
    import mikd_pkg::*;

    logic             valid;
    logic             ready;
    logic [ENV_W-1:0] envelope;

    modport source (output valid, output envelope, input ready);
    modport sink   (input valid, input envelope, output ready);
endinterface

`default_nettype wire

// File: hdl/mikd_res_if.sv
// ----------------------------------------------------------------------------
// mikd_res_if
// per-sample result channel: key bit, symbol code, noise floor
// ----------------------------------------------------------------------------
`default_nettype none

interface mikd_res_if;
    import mikd_pkg::*;

    logic             valid;
    logic             ready;
    logic             key_bit;
    logic [SYM_W-1:0] symbol;
    logic [ENV_W-1:0] noise_floor;

    modport source (output valid, output key_bit, output symbol, output noise_floor,
                    input ready);
    modport sink   (input valid, input key_bit, input symbol, input noise_floor,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/morse_ident_keying_detector_core.sv
// Morse ident keying detector. Each envelope sample is taken in the idle state
// and passes through the multiply and decision states before its result is
// registered; when it closes a half-dot bin, a scan state first finds the noise
// floor by scanning the bin maxima one per clock. No new sample is taken until
// the last one is through its decision step. The result register lets the next
// sample be taken while a result still waits downstream; its decision step then
// stalls until that result is transferred. The user must write registers through
// the plain write port while no sample is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
// morse_ident_keying_detector_core
// key detection against a tracked noise floor with dot/dash/gap timing
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module morse_ident_keying_detector_core #(
    parameter int NUM_BINS = mikd_pkg::NUM_BINS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    mikd_env_if.sink                         i_env_ch,
    mikd_res_if.source                       o_res_ch,
    input  wire                              i_cfg_we,
    input  wire [mikd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [mikd_pkg::CFG_W-1:0]        i_cfg_data
);
    import mikd_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    // sequencer
    mikd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_env_ch.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    mikd_dp #(
        .NUM_BINS (NUM_BINS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_envelope (i_env_ch.envelope),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_res_ch   (o_res_ch)
    );

    assign i_env_ch.ready = in_ready;

    // checks
    `ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_env_ch.valid && i_env_ch.ready, !i_env_ch.ready, "sample taken while busy")
    `ASSERT_IMPLIES(a_commit_free, i_clk, i_rst_n, cmd.commit, sts.out_free, "result overwritten")
    `ASSERT_IMPLIES(a_valid_rise, i_clk, i_rst_n, $rose(o_res_ch.valid), $past(cmd.commit), "result without decision")
    `ASSERT_IMPLIES(a_floor_nonzero, i_clk, i_rst_n, o_res_ch.valid, o_res_ch.noise_floor != '0, "zero noise floor")

endmodule

`default_nettype wire

// File: hdl/mikd_ctrl.sv
// ----------------------------------------------------------------------------
// mikd_ctrl
// sequencer: accept, optional bin minimum scan, multiply, decide and issue
// ----------------------------------------------------------------------------
`default_nettype none

module mikd_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire mikd_pkg::t_sts  i_sts,
    output mikd_pkg::t_cmd       o_cmd
);
    import mikd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_DEC
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.roll_needed ? S_SCAN : S_MUL;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    o_cmd.roll = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DEC;
            end
            S_DEC: begin
                // hold until the result register can take the transfer
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: hdl/mikd_dp.sv
// ----------------------------------------------------------------------------
// mikd_dp
// datapath: bin maxima, noise floor, key threshold, mark/space timer
// ----------------------------------------------------------------------------
`default_nettype none

module mikd_dp #(
    parameter int NUM_BINS = mikd_pkg::NUM_BINS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire mikd_pkg::t_cmd              i_cmd,
    output mikd_pkg::t_sts                   o_sts,
    input  wire [mikd_pkg::ENV_W-1:0]        i_envelope,
    input  wire                              i_cfg_we,
    input  wire [mikd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [mikd_pkg::CFG_W-1:0]        i_cfg_data,
    mikd_res_if.source                       o_res_ch
);
    import mikd_pkg::*;

    localparam int IW = $clog2(NUM_BINS);
    localparam logic [IW-1:0] LAST_BIN = IW'(NUM_BINS - 1);

    // configuration
    logic [CFG_W-1:0] r_fast;
    logic [CFG_W-1:0] r_slow;
    logic [THR_W-1:0] r_thr;

    // bin tracking; the current bin's maximum lives in r_cur_max
    logic [ENV_W-1:0] r_bins [NUM_BINS];
    logic [ENV_W-1:0] r_cur_max;
    logic [IW-1:0]    r_bin_idx;
    logic [CNT_W-1:0] r_count;
    logic [ENV_W-1:0] r_floor;

    // key timing
    logic             r_prev_key;
    logic [RUN_W-1:0] r_run;
    logic             r_pending;

    // working registers
    logic [ENV_W-1:0] r_env;
    logic [IW-1:0]    r_scan_idx;
    logic [ENV_W-1:0] r_min;
    logic [RUN_W-1:0] r_prod;
    logic [18:0]      r_lim7;
    logic [18:0]      r_lim5;
    logic [19:0]      r_lim10;
    logic [26:0]      r_run5;

    // result register
    logic             r_o_valid;
    logic             r_o_key;
    logic [SYM_W-1:0] r_o_sym;
    logic [ENV_W-1:0] r_o_floor;

    // sample count and rollover test
    logic [CNT_W-1:0] count_inc;
    logic             roll_needed;
    assign count_inc   = (r_count == CNT_MAX) ? r_count : r_count + 1'b1;
    assign roll_needed = count_inc >= {1'b0, r_fast[CFG_W-1:1]};

    // minimum scan step
    logic [ENV_W-1:0] scan_val;
    logic [ENV_W-1:0] min_next;
    logic [IW-1:0]    bin_next;
    assign scan_val = (r_scan_idx == r_bin_idx) ? r_cur_max : r_bins[r_scan_idx];
    assign min_next = (scan_val < r_min) ? scan_val : r_min;
    assign bin_next = (r_bin_idx == LAST_BIN) ? '0 : r_bin_idx + 1'b1;

    // threshold product
    logic [RUN_W-1:0] prod_w;
    assign prod_w = RUN_W'(r_thr) * RUN_W'(r_floor);

    // key decision and timer update
    logic             key;
    logic [RUN_W-1:0] run_inc;
    logic [SYM_W-1:0] sym;
    logic [RUN_W-1:0] run_new;
    logic             pend_new;
    assign key     = {4'b0, r_env, 4'b0} >= r_prod;
    assign run_inc = (r_run == RUN_MAX) ? r_run : r_run + 1'b1;

    always_comb begin
        sym      = SYM_NONE;
        run_new  = r_run;
        pend_new = r_pending;
        priority if (!r_prev_key && key) begin
            // mark begins: long space ends the ident, medium one ends a letter
            if (r_run > {5'b0, r_lim7}) begin
                if (r_pending) begin
                    sym      = SYM_END;
                    pend_new = 1'b0;
                end
            end else if ({r_run, 1'b0} > {6'b0, r_lim5}) begin
                sym = SYM_GAP;
            end
            run_new = '0;
        end else if (key) begin
            run_new = run_inc;
        end else if (r_prev_key) begin
            // mark ends: classify its length
            if (r_run > {7'b0, r_fast, 1'b0}) begin
                sym      = SYM_DASH;
                pend_new = 1'b1;
            end else if (r_run5 > {11'b0, r_fast}) begin
                sym      = SYM_DOT;
                pend_new = 1'b1;
            end
            run_new = '0;
        end else begin
            // quiet timeout
            run_new = run_inc;
            if (run_inc > {4'b0, r_lim10}) begin
                if (r_pending) begin
                    sym      = SYM_END;
                    pend_new = 1'b0;
                end
                run_new = '0;
            end
        end
    end

    // status
    assign o_sts.roll_needed = roll_needed;
    assign o_sts.scan_last   = r_scan_idx == LAST_BIN;
    assign o_sts.out_free    = !r_o_valid || o_res_ch.ready;

    // state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast     <= FAST_RST;
            r_slow     <= SLOW_RST;
            r_thr      <= THR_RST;
            for (int i = 0; i < NUM_BINS; i++) begin
                r_bins[i] <= '0;
            end
            r_cur_max  <= '0;
            r_bin_idx  <= '0;
            r_count    <= '0;
            r_floor    <= FLOOR_RST;
            r_prev_key <= 1'b0;
            r_run      <= '0;
            r_pending  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            // register writes, unknown indexes ignored
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FAST: r_fast <= i_cfg_data;
                    CFG_SLOW: r_slow <= i_cfg_data;
                    CFG_THR:  r_thr  <= i_cfg_data[THR_W-1:0];
                    default:  ;
                endcase
            end
            // sample intake
            if (i_cmd.load) begin
                if (i_envelope > r_cur_max) begin
                    r_cur_max <= i_envelope;
                end
                r_count <= roll_needed ? '0 : count_inc;
            end
            // close the bin at the end of the scan
            if (i_cmd.roll) begin
                r_floor            <= (min_next == '0) ? ENV_W'(1) : min_next;
                r_bins[r_bin_idx]  <= r_cur_max;
                r_cur_max          <= '0;
                r_bin_idx          <= bin_next;
            end
            // decision
            if (i_cmd.commit) begin
                r_prev_key <= key;
                r_run      <= run_new;
                r_pending  <= pend_new;
            end
            // result transfer
            if (i_cmd.commit) begin
                r_o_valid <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_env      <= i_envelope;
            r_scan_idx <= '0;
            r_min      <= {ENV_W{1'b1}};
        end
        if (i_cmd.scan) begin
            r_scan_idx <= r_scan_idx + 1'b1;
            r_min      <= min_next;
        end
        if (i_cmd.mul) begin
            r_prod  <= prod_w;
            r_lim7  <= {r_fast, 3'b0} - {3'b0, r_fast};
            r_lim5  <= {1'b0, r_fast, 2'b0} + {3'b0, r_fast};
            r_lim10 <= {1'b0, r_slow, 3'b0} + {3'b0, r_slow, 1'b0};
            r_run5  <= {1'b0, r_run, 2'b0} + {3'b0, r_run};
        end
        if (i_cmd.commit) begin
            r_o_key   <= key;
            r_o_sym   <= sym;
            r_o_floor <= r_floor;
        end
    end

    assign o_res_ch.valid       = r_o_valid;
    assign o_res_ch.key_bit     = r_o_key;
    assign o_res_ch.symbol      = r_o_sym;
    assign o_res_ch.noise_floor = r_o_floor;

endmodule

`default_nettype wire
